// ===== src/point_segment_closest_point_macros.svh =====
// Assertion macros for the closest point block
`ifndef POINT_SEGMENT_CLOSEST_POINT_MACROS_SVH
`define POINT_SEGMENT_CLOSEST_POINT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define PSCP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define PSCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/pscp_pkg.sv =====
// ----------------------------------------------------------------------------
// pscp_pkg
// Types, widths and codes shared by the closest point block.
// ----------------------------------------------------------------------------
package pscp_pkg;
    localparam int CoordBits = 32;
    localparam int FracBits  = 16;
    localparam int PosBits   = FracBits + 1;
    localparam int DistBits  = CoordBits + 1;
    localparam int DiffBits  = CoordBits + 1;      // B-A, P-A, P-N magnitudes fit in 33
    localparam int ProdBits  = 2 * DiffBits;       // 66
    localparam int SumBits   = ProdBits + 2;       // 68, sum of three products
    localparam int NumBits   = SumBits;
    localparam int QBits     = DiffBits;           // offset below |d|
    localparam int DivBits   = FracBits + DiffBits; // quotient bits produced per division
    localparam int SqBits    = SumBits;
    localparam int RootBits  = SqBits / 2;         // 34
    localparam int FifoDepth = 4;
    localparam int FifoAw    = $clog2(FifoDepth);

    localparam logic [1:0] CaseZero     = 2'd0;
    localparam logic [1:0] CaseClampA   = 2'd1;
    localparam logic [1:0] CaseClampB   = 2'd2;
    localparam logic [1:0] CaseInterior = 2'd3;

    typedef logic signed [CoordBits-1:0] coord_t;

    typedef struct packed {
        coord_t end_a_x; coord_t end_a_y; coord_t end_a_z;
        coord_t end_b_x; coord_t end_b_y; coord_t end_b_z;
        coord_t query_x; coord_t query_y; coord_t query_z;
    } seg_in_t;

    typedef struct packed {
        coord_t                near_x;
        coord_t                near_y;
        coord_t                near_z;
        logic [PosBits-1:0]    segment_position;
        logic [DistBits-1:0]   distance;
        logic [1:0]            case_code;
    } seg_out_t;

    // classified work item passed from front to back
    typedef struct packed {
        logic [1:0]              code;
        logic [2:0]              dneg;
        logic [3*DiffBits-1:0]   dmag;
        logic [NumBits-1:0]      num;
        logic [SumBits-1:0]      den;
        logic [3*CoordBits-1:0]  a;
        logic [3*CoordBits-1:0]  b;
        logic [3*CoordBits-1:0]  p;
    } work_t;

    // queue status: full holds the front, empty gates the back
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;
endpackage

// ===== src/pscp_if.sv =====
// ----------------------------------------------------------------------------
// pscp_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface pscp_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/point_segment_closest_point.sv =====
// Path from the input transfer to output valid with no stalls: two front
// stages (the transfer loads the first), the queue and 87 back stages.
// Throughput: one query per cycle while out_ch does not stall; the back end's
// bit-per-stage divider and square root pipeline set the depth.
// Reset: rst_n clears valid flags, queue pointers and back stages asynchronously.
// ----------------------------------------------------------------------------
// point_segment_closest_point
// Closest point on a 3D segment, clamped position and distance.
// ----------------------------------------------------------------------------
module point_segment_closest_point
(
    input  logic   clk,
    input  logic   rst_n,
    pscp_if.sink   in_ch,
    pscp_if.source out_ch
);
    logic             fvalid, take, stall;
    pscp_pkg::work_t  fdata, qdata;
    pscp_pkg::qstat_t qs;

    // hold the front while the queue is full
    assign stall = qs.full;

    pscp_front u_front (.clk, .rst_n, .in_ch, .wvalid(fvalid), .wdata(fdata),
                        .wstall(stall));
    pscp_queue u_queue (.clk, .rst_n, .push(fvalid && !qs.full), .push_data(fdata),
                        .pop(take), .pop_data(qdata), .stat(qs));
    pscp_back  u_back  (.clk, .rst_n, .wvalid(!qs.empty), .wdata(qdata),
                        .wtake(take), .out_ch);
endmodule

// ===== src/pscp_front.sv =====
// ----------------------------------------------------------------------------
// pscp_front
// Accept a query, form num = dot(P-A, B-A) and den = |B-A|^2, classify it.
// Two stages: products, then sums and compares.
// ----------------------------------------------------------------------------
module pscp_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    pscp_if.sink                    in_ch,
    output logic                    wvalid,
    output pscp_pkg::work_t         wdata,
    input  logic                    wstall
);
    localparam int D = pscp_pkg::DiffBits;
    localparam int C = pscp_pkg::CoordBits;
    localparam int P = pscp_pkg::ProdBits;
    localparam int S = pscp_pkg::SumBits;

    logic                 v1_reg, v2_reg;
    logic [2:0]           dneg1_reg, wneg1_reg;
    logic [D-1:0]         dm1_reg [3];
    logic [P-1:0]         pw1_reg [3];
    logic [P-1:0]         pd1_reg [3];
    logic [3*C-1:0]       a1_reg, b1_reg, p1_reg;
    pscp_pkg::work_t      w2_reg, w2_next;
    logic                 adv;

    logic signed [C-1:0] av [3];
    logic signed [C-1:0] bv [3];
    logic signed [C-1:0] pv [3];
    logic signed [D-1:0] dd [3];
    logic signed [D-1:0] ww [3];
    logic [D-1:0]        dmag [3];
    logic [D-1:0]        wmag [3];

    assign adv = !(v2_reg && wstall);
    assign in_ch.ready = adv;
    assign wvalid = v2_reg;
    assign wdata  = w2_reg;

    assign av[0] = in_ch.data.end_a_x; assign av[1] = in_ch.data.end_a_y;
    assign av[2] = in_ch.data.end_a_z;
    assign bv[0] = in_ch.data.end_b_x; assign bv[1] = in_ch.data.end_b_y;
    assign bv[2] = in_ch.data.end_b_z;
    assign pv[0] = in_ch.data.query_x; assign pv[1] = in_ch.data.query_y;
    assign pv[2] = in_ch.data.query_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dd[i]   = D'(bv[i]) - D'(av[i]);
            ww[i]   = D'(pv[i]) - D'(av[i]);
            dmag[i] = dd[i][D-1] ? D'(-dd[i]) : D'(dd[i]);
            wmag[i] = ww[i][D-1] ? D'(-ww[i]) : D'(ww[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dneg1_reg[i] <= dd[i][D-1];
                wneg1_reg[i] <= ww[i][D-1];
                dm1_reg[i]   <= dmag[i];
                pw1_reg[i]   <= P'(dmag[i]) * P'(wmag[i]);
                pd1_reg[i]   <= P'(dmag[i]) * P'(dmag[i]);
            end
            a1_reg <= {av[0], av[1], av[2]};
            b1_reg <= {bv[0], bv[1], bv[2]};
            p1_reg <= {pv[0], pv[1], pv[2]};
            w2_reg <= w2_next;
        end
    end

    logic [S-1:0] pos, neg, den, num;
    always_comb
    begin
        pos = '0;
        neg = '0;
        den = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (dneg1_reg[i] != wneg1_reg[i])
                neg = neg + S'(pw1_reg[i]);
            else
                pos = pos + S'(pw1_reg[i]);
            den = den + S'(pd1_reg[i]);
        end
        num = pos - neg;
        w2_next      = '0;
        w2_next.dneg = dneg1_reg;
        w2_next.dmag = {dm1_reg[0], dm1_reg[1], dm1_reg[2]};
        w2_next.num  = num;
        w2_next.den  = den;
        w2_next.a    = a1_reg;
        w2_next.b    = b1_reg;
        w2_next.p    = p1_reg;
        if (den == '0)
            w2_next.code = pscp_pkg::CaseZero;
        else if (pos <= neg)
            w2_next.code = pscp_pkg::CaseClampA;
        else if (num >= den)
            w2_next.code = pscp_pkg::CaseClampB;
        else
            w2_next.code = pscp_pkg::CaseInterior;
    end
endmodule

// ===== src/pscp_queue.sv =====
// ----------------------------------------------------------------------------
// pscp_queue
// Short queue of classified work items between front and back.
// ----------------------------------------------------------------------------
`include "point_segment_closest_point_macros.svh"
module pscp_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pscp_pkg::work_t      push_data,
    input  logic                 pop,
    output pscp_pkg::work_t      pop_data,
    output pscp_pkg::qstat_t     stat
);
    localparam int A = pscp_pkg::FifoAw;

    pscp_pkg::work_t mem [pscp_pkg::FifoDepth];
    logic [A-1:0] wr_reg, rd_reg;
    logic [A:0]   cnt_reg;

    assign stat.full  = (cnt_reg == (A+1)'(pscp_pkg::FifoDepth));
    assign stat.empty = (cnt_reg == '0);
    assign pop_data   = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (A+1)'(push) - (A+1)'(pop);
        end
    end

    `PSCP_ASSERT_IMP(no_overflow, push && !pop, !stat.full)
    `PSCP_ASSERT_IMP(no_underflow, pop, !stat.empty)
    `PSCP_ASSERT_NEXT(count_moves, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)
endmodule

// ===== src/pscp_back.sv =====
// ----------------------------------------------------------------------------
// pscp_back
// Split multiply, pipelined restoring divider, near point, squared distance
// and pipelined integer square root; one item may enter each cycle unless the output stalls.
// ----------------------------------------------------------------------------
module pscp_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wvalid,
    input  pscp_pkg::work_t      wdata,
    output logic                 wtake,
    pscp_if.source               out_ch
);
    localparam int C  = pscp_pkg::CoordBits;
    localparam int D  = pscp_pkg::DiffBits;
    localparam int S  = pscp_pkg::SumBits;
    localparam int FB = pscp_pkg::FracBits;
    localparam int QB = pscp_pkg::DivBits;
    localparam int R  = pscp_pkg::RootBits;
    localparam int RW = R + 2;
    localparam int NP = QB + 2;           // near point stage
    localparam int SQ = QB + 3;           // squared distance stage
    localparam int NS = QB + R + 4;       // total stages
    localparam int NW = S + D;            // dividend width num*|d|

    // stage 0 partial products, stage 1 dividends, stages 2..QB+1 divide,
    // then near point, squares and one root bit per stage
    typedef struct packed {
        logic                  v;
        logic [1:0]            code;
        logic [2:0]            dneg;
        logic [3*D-1:0]        dmag;
        logic [S-1:0]          den;
        logic [3*C-1:0]        a, b, p;
        logic [S-1:0]          nt;
        logic [2:0][2*D-1:0]   plo;        // low half of num times |d|
        logic [2:0][2*D-1:0]   phi;        // high half of num times |d|
        logic [3:0][S+1:0]     rem;        // partial remainders: t, x, y, z
        logic [3:0][NW-1:0]    dvd;        // dividends shifting out
        logic [3:0][QB-1:0]    quo;
        logic [2:0][D-1:0]     em;         // |P - N| per axis
        logic [S-1:0]          sq;         // radicand
        logic [RW-1:0]         rrem;
        logic [R-1:0]          root;
    } st_t;

    st_t st_reg [NS];
    st_t st_next [NS];
    logic adv;

    assign adv   = !(st_reg[NS-1].v && !out_ch.ready);
    assign wtake = adv && wvalid;

    always_comb
    begin
        // stage 0: load and form the partial products
        st_next[0]      = '0;
        st_next[0].v    = wvalid;
        st_next[0].code = wdata.code;
        st_next[0].dneg = wdata.dneg;
        st_next[0].dmag = wdata.dmag;
        st_next[0].den  = (wdata.den == '0) ? S'(1) : wdata.den;
        st_next[0].a    = wdata.a;
        st_next[0].b    = wdata.b;
        st_next[0].p    = wdata.p;
        st_next[0].nt   = wdata.num;
        for (int k = 0; k < 3; k++)
        begin
            st_next[0].plo[k] = (2*D)'(wdata.num[D-1:0])
                * (2*D)'(wdata.dmag[(2-k)*D +: D]);
            st_next[0].phi[k] = (2*D)'(wdata.num[2*D-1:D])
                * (2*D)'(wdata.dmag[(2-k)*D +: D]);
        end
        for (int s = 1; s < NS; s++)
            st_next[s] = st_reg[s-1];
        // stage 1: dividends; bits above QB seed the remainder
        st_next[1].dvd[0] = NW'(st_reg[0].nt) << FB;
        for (int k = 1; k < 4; k++)
            st_next[1].dvd[k] = (NW'(st_reg[0].phi[k-1]) << D)
                + NW'(st_reg[0].plo[k-1]) + NW'(st_reg[0].den >> 1);
        for (int k = 0; k < 4; k++)
            st_next[1].rem[k] = (S+2)'(st_next[1].dvd[k] >> QB);
        // division stages: one quotient bit each
        for (int s = 2; s <= QB + 1; s++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                logic [S+1:0] r;
                r = {st_reg[s-1].rem[k][S:0],
                     st_reg[s-1].dvd[k][QB+1-s]};
                if (r >= (S+2)'(st_reg[s-1].den))
                begin
                    st_next[s].rem[k] = r - (S+2)'(st_reg[s-1].den);
                    st_next[s].quo[k][QB+1-s] = 1'b1;
                end
                else
                begin
                    st_next[s].rem[k] = r;
                    st_next[s].quo[k][QB+1-s] = 1'b0;
                end
            end
        end
        // near point and per-axis distance magnitude
        begin
            st_t q;
            logic signed [C-1:0] nn [3];
            logic signed [D-1:0] e;
            q = st_reg[NP-1];
            for (int i = 0; i < 3; i++)
            begin
                case (q.code)
                    pscp_pkg::CaseClampB:   nn[i] = q.b[(2-i)*C +: C];
                    pscp_pkg::CaseInterior:
                        nn[i] = q.dneg[i]
                            ? q.a[(2-i)*C +: C] - C'(q.quo[i+1])
                            : q.a[(2-i)*C +: C] + C'(q.quo[i+1]);
                    default:                nn[i] = q.a[(2-i)*C +: C];
                endcase
                e = D'(signed'(q.p[(2-i)*C +: C])) - D'(nn[i]);
                st_next[NP].em[i] = e[D-1] ? D'(-e) : D'(e);
            end
            st_next[NP].a = {nn[0], nn[1], nn[2]};
            if (q.code == pscp_pkg::CaseInterior)
                st_next[NP].quo[0] = q.quo[0];
            else if (q.code == pscp_pkg::CaseClampB)
                st_next[NP].quo[0] = QB'(1) << FB;
            else
                st_next[NP].quo[0] = '0;
        end
        // squared distance
        begin
            logic [S-1:0] acc;
            acc = '0;
            for (int i = 0; i < 3; i++)
                acc = acc + S'(S'(st_reg[SQ-1].em[i]) * S'(st_reg[SQ-1].em[i]));
            st_next[SQ].sq   = acc;
            st_next[SQ].rrem = '0;
            st_next[SQ].root = '0;
        end
        // square root: one result bit per stage
        for (int s = SQ + 1; s < NS; s++)
        begin
            logic [RW-1:0] r, t;
            int j;
            j = NS - 1 - s;
            r = {st_reg[s-1].rrem[RW-3:0], st_reg[s-1].sq[2*j+1 -: 2]};
            t = {st_reg[s-1].root, 2'b01};
            if (r >= t)
            begin
                st_next[s].rrem = r - t;
                st_next[s].root = {st_reg[s-1].root[R-2:0], 1'b1};
            end
            else
            begin
                st_next[s].rrem = r;
                st_next[s].root = {st_reg[s-1].root[R-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                st_reg[s] <= '0;
        end
        else if (adv)
        begin
            for (int s = 0; s < NS; s++)
                st_reg[s] <= st_next[s];
        end
    end

    logic [R-1:0] rt;
    assign rt = st_reg[NS-1].root;
    assign out_ch.valid = st_reg[NS-1].v;
    assign out_ch.data.near_x = st_reg[NS-1].a[2*C +: C];
    assign out_ch.data.near_y = st_reg[NS-1].a[C +: C];
    assign out_ch.data.near_z = st_reg[NS-1].a[0 +: C];
    assign out_ch.data.segment_position = st_reg[NS-1].quo[0][pscp_pkg::PosBits-1:0];
    assign out_ch.data.distance = (rt[R-1:pscp_pkg::DistBits] != '0)
        ? '1 : rt[pscp_pkg::DistBits-1:0];
    assign out_ch.data.case_code = st_reg[NS-1].code;
endmodule
